[sv/olist_pkg.sv]
// Shared types and codes for the ordered list engine.
// Word formats, command and result codes, controller states and datapath operations.
// No dependencies.
`timescale 1ns / 1ps

package olist_pkg;

   // Command codes of the request word
   localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
   localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
   localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
   localparam logic [2:0] CMD_POP_BACK   = 3'd3;
   localparam logic [2:0] CMD_FIND       = 3'd4;
   localparam logic [2:0] CMD_REMOVE     = 3'd5;

   // Result status codes
   localparam logic [1:0] RES_OK        = 2'd0;
   localparam logic [1:0] RES_EMPTY     = 2'd1;
   localparam logic [1:0] RES_NOT_FOUND = 2'd2;
   localparam logic [1:0] RES_FULL      = 2'd3;

   typedef struct packed {
      logic [2:0]         cmd;
      logic signed [31:0] item_value;
   } req_word_type;

   typedef struct packed {
      logic [1:0] status;
      logic       found;
      logic [5:0] position;
      logic [6:0] count;
      logic       empty_res;
   } rsp_word_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_ALLOC_TAKE,
      S_PUSH,
      S_POP_FRONT,
      S_WALK,
      S_REMOVE_HEAD,
      S_UNLINK,
      S_TRIM,
      S_RELEASE,
      S_FINISH
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_ALLOC_FRESH,
      OP_ALLOC_READ,
      OP_ALLOC_TAKE,
      OP_PUSH_FRONT,
      OP_PUSH_BACK,
      OP_HEAD_READ,
      OP_POP_FRONT,
      OP_WALK_STEP,
      OP_WALK_STOP,
      OP_REMOVE_HEAD,
      OP_UNLINK,
      OP_TRIM,
      OP_RELEASE,
      OP_RESULT
   } dp_op_type;

   // Controller to datapath
   typedef struct packed {
      dp_op_type  op;
      logic [1:0] res_code;
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic [2:0] cmd;
      logic       count_zero;
      logic       count_one;
      logic       full;
      logic       fresh_avail;
      logic       match;
      logic       at_first;
      logic       at_last;
      logic       at_penult;
      logic       rsp_free;
   } dp_stat_type;

endpackage

[sv/olist_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Used for the value and link stores. No dependencies.
`timescale 1ns / 1ps

module olist_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/olist_datapath.sv]
// Datapath of the ordered list engine: list pointers, slot allocator, walk registers,
// the two stores and the result register. Depends on olist_pkg and olist_ram.
`timescale 1ns / 1ps

module olist_datapath #(
   parameter int DEPTH = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  olist_pkg::req_word_type req_data,
   input  olist_pkg::ctrl_cmd_type ctrl_cmd,
   output olist_pkg::dp_stat_type  dp_stat,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output olist_pkg::rsp_word_type rsp_data
);

   import olist_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = (CW > 7) ? CW : 7;
   localparam int PW = (AW > 6) ? AW : 6;

   logic [2:0]    cmd_ff, cmd_in;
   logic [31:0]   val_ff, val_in;
   logic [AW-1:0] head_ff, head_in;
   logic [AW-1:0] tail_ff, tail_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] fresh_ff, fresh_in;
   logic [AW-1:0] free_head_ff, free_head_in;
   logic [AW-1:0] slot_ff, slot_in;
   logic [AW-1:0] cur_ff, cur_in;
   logic [AW-1:0] prev_ff, prev_in;
   logic [AW-1:0] next_ff, next_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_word_type  rsp_data_ff, rsp_data_in;

   logic          val_wr_en;
   logic          link_wr_en;
   logic [AW-1:0] val_wr_addr;
   logic [AW-1:0] link_wr_addr;
   logic [AW-1:0] link_wr_data;
   logic [AW-1:0] rd_addr;
   logic [31:0]   val_rd_data;
   logic [AW-1:0] link_rd_data;

   logic [CW-1:0] idx_wide;
   logic          is_search;
   logic          found;
   logic [XW-1:0] count_x;
   logic [PW-1:0] pos_x;

   olist_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_value_ram (
      .clock   (clock),
      .wr_en   (val_wr_en),
      .wr_addr (val_wr_addr),
      .wr_data (val_ff),
      .rd_addr (rd_addr),
      .rd_data (val_rd_data)
   );

   olist_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_wr_en),
      .wr_addr (link_wr_addr),
      .wr_data (link_wr_data),
      .rd_addr (rd_addr),
      .rd_data (link_rd_data)
   );

   assign idx_wide  = CW'(idx_ff);
   assign is_search = (cmd_ff == CMD_FIND) || (cmd_ff == CMD_REMOVE);
   assign found     = (ctrl_cmd.res_code == RES_OK) && is_search;
   assign count_x   = XW'(count_ff);
   assign pos_x     = found ? PW'(idx_ff) : '0;

   always_comb begin
      dp_stat.cmd         = cmd_ff;
      dp_stat.count_zero  = (count_ff == '0);
      dp_stat.count_one   = (count_ff == CW'(1));
      dp_stat.full        = (count_ff == CW'(DEPTH));
      dp_stat.fresh_avail = (fresh_ff != CW'(DEPTH));
      dp_stat.match       = (val_rd_data == val_ff);
      dp_stat.at_first    = (idx_ff == '0);
      dp_stat.at_last     = (idx_wide == count_ff - CW'(1));
      dp_stat.at_penult   = (idx_wide == count_ff - CW'(2));
      dp_stat.rsp_free    = !rsp_valid_ff || rsp_ready;
   end

   // Store ports
   always_comb begin
      val_wr_en    = 1'b0;
      val_wr_addr  = slot_ff;
      link_wr_en   = 1'b0;
      link_wr_addr = slot_ff;
      link_wr_data = head_ff;
      case (ctrl_cmd.op)
         OP_ALLOC_READ: rd_addr = free_head_ff;
         OP_HEAD_READ:  rd_addr = head_ff;
         OP_WALK_STEP:  rd_addr = link_rd_data;
         default:       rd_addr = cur_ff;
      endcase
      case (ctrl_cmd.op)
         OP_PUSH_FRONT: begin
            val_wr_en  = 1'b1;
            link_wr_en = 1'b1;
         end
         OP_PUSH_BACK: begin
            val_wr_en    = 1'b1;
            link_wr_en   = (count_ff != '0);
            link_wr_addr = tail_ff;
            link_wr_data = slot_ff;
         end
         OP_UNLINK: begin
            link_wr_en   = 1'b1;
            link_wr_addr = prev_ff;
            link_wr_data = next_ff;
         end
         OP_RELEASE: begin
            link_wr_en   = 1'b1;
            link_wr_data = free_head_ff;
         end
         default: begin
         end
      endcase
   end

   // Register updates
   always_comb begin
      cmd_in       = cmd_ff;
      val_in       = val_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      fresh_in     = fresh_ff;
      free_head_in = free_head_ff;
      slot_in      = slot_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      next_in      = next_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      case (ctrl_cmd.op)
         OP_LOAD: begin
            cmd_in = req_data.cmd;
            val_in = req_data.item_value;
         end
         OP_ALLOC_FRESH: begin
            slot_in  = fresh_ff[AW-1:0];
            fresh_in = fresh_ff + CW'(1);
         end
         OP_ALLOC_TAKE: begin
            slot_in      = free_head_ff;
            free_head_in = link_rd_data;
         end
         OP_PUSH_FRONT: begin
            head_in  = slot_ff;
            tail_in  = (count_ff == '0) ? slot_ff : tail_ff;
            count_in = count_ff + CW'(1);
         end
         OP_PUSH_BACK: begin
            tail_in  = slot_ff;
            head_in  = (count_ff == '0) ? slot_ff : head_ff;
            count_in = count_ff + CW'(1);
         end
         OP_HEAD_READ: begin
            cur_in  = head_ff;
            prev_in = head_ff;
            idx_in  = '0;
         end
         OP_POP_FRONT: begin
            slot_in  = head_ff;
            head_in  = link_rd_data;
            count_in = count_ff - CW'(1);
            if (count_ff == CW'(1)) begin
               head_in = '0;
               tail_in = '0;
            end
         end
         OP_WALK_STEP: begin
            next_in = link_rd_data;
            prev_in = cur_ff;
            cur_in  = link_rd_data;
            idx_in  = idx_ff + AW'(1);
         end
         OP_WALK_STOP: begin
            next_in = link_rd_data;
         end
         OP_REMOVE_HEAD: begin
            slot_in  = cur_ff;
            head_in  = next_ff;
            count_in = count_ff - CW'(1);
            if (count_ff == CW'(1)) begin
               head_in = '0;
               tail_in = '0;
            end
         end
         OP_UNLINK: begin
            slot_in  = cur_ff;
            tail_in  = (idx_wide == count_ff - CW'(1)) ? prev_ff : tail_ff;
            count_in = count_ff - CW'(1);
         end
         OP_TRIM: begin
            slot_in  = tail_ff;
            tail_in  = cur_ff;
            count_in = count_ff - CW'(1);
         end
         OP_RELEASE: begin
            free_head_in = slot_ff;
         end
         OP_RESULT: begin
            rsp_valid_in          = 1'b1;
            rsp_data_in.status    = ctrl_cmd.res_code;
            rsp_data_in.found     = found;
            rsp_data_in.position  = pos_x[5:0];
            rsp_data_in.count     = count_x[6:0];
            rsp_data_in.empty_res = (count_ff == '0);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         fresh_ff     <= '0;
         free_head_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         fresh_ff     <= fresh_in;
         free_head_ff <= free_head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      val_ff      <= val_in;
      slot_ff     <= slot_in;
      cur_ff      <= cur_in;
      prev_ff     <= prev_in;
      next_ff     <= next_in;
      idx_ff      <= idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[sv/olist_ctrl.sv]
// Controller state machine of the ordered list engine: sequences the datapath operations
// of each command and picks the result status. Depends on olist_pkg.
`timescale 1ns / 1ps

module olist_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  olist_pkg::dp_stat_type  dp_stat,
   output olist_pkg::ctrl_cmd_type ctrl_cmd
);

   import olist_pkg::*;

   state_type  state_ff, state_in;
   logic [1:0] code_ff, code_in;
   logic       is_search;
   logic       walk_stop;

   assign is_search = (dp_stat.cmd == CMD_FIND) || (dp_stat.cmd == CMD_REMOVE);
   assign walk_stop = is_search ? (dp_stat.match || dp_stat.at_last) : dp_stat.at_penult;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         code_ff  <= RES_OK;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
      end
   end

   always_comb begin
      state_in          = state_ff;
      code_in           = code_ff;
      req_ready         = 1'b0;
      ctrl_cmd.op       = OP_NONE;
      ctrl_cmd.res_code = code_ff;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctrl_cmd.op = OP_LOAD;
               state_in    = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            code_in  = RES_OK;
            state_in = S_FINISH;
            case (dp_stat.cmd)
               CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                  if (dp_stat.full) begin
                     code_in = RES_FULL;
                  end else if (dp_stat.fresh_avail) begin
                     ctrl_cmd.op = OP_ALLOC_FRESH;
                     state_in    = S_PUSH;
                  end else begin
                     ctrl_cmd.op = OP_ALLOC_READ;
                     state_in    = S_ALLOC_TAKE;
                  end
               end
               CMD_POP_FRONT, CMD_POP_BACK, CMD_FIND, CMD_REMOVE: begin
                  if (dp_stat.count_zero) begin
                     code_in = RES_EMPTY;
                  end else begin
                     ctrl_cmd.op = OP_HEAD_READ;
                     if (dp_stat.cmd == CMD_POP_FRONT ||
                         (dp_stat.cmd == CMD_POP_BACK && dp_stat.count_one)) begin
                        state_in = S_POP_FRONT;
                     end else begin
                        state_in = S_WALK;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         S_ALLOC_TAKE: begin
            ctrl_cmd.op = OP_ALLOC_TAKE;
            state_in    = S_PUSH;
         end
         S_PUSH: begin
            ctrl_cmd.op = (dp_stat.cmd == CMD_PUSH_FRONT) ? OP_PUSH_FRONT : OP_PUSH_BACK;
            state_in    = S_FINISH;
         end
         S_POP_FRONT: begin
            ctrl_cmd.op = OP_POP_FRONT;
            state_in    = S_RELEASE;
         end
         S_WALK: begin
            if (!walk_stop) begin
               ctrl_cmd.op = OP_WALK_STEP;
            end else begin
               ctrl_cmd.op = OP_WALK_STOP;
               if (dp_stat.cmd == CMD_POP_BACK) begin
                  state_in = S_TRIM;
               end else if (!dp_stat.match) begin
                  code_in  = RES_NOT_FOUND;
                  state_in = S_FINISH;
               end else if (dp_stat.cmd == CMD_FIND) begin
                  state_in = S_FINISH;
               end else if (dp_stat.at_first) begin
                  state_in = S_REMOVE_HEAD;
               end else begin
                  state_in = S_UNLINK;
               end
            end
         end
         S_REMOVE_HEAD: begin
            ctrl_cmd.op = OP_REMOVE_HEAD;
            state_in    = S_RELEASE;
         end
         S_UNLINK: begin
            ctrl_cmd.op = OP_UNLINK;
            state_in    = S_RELEASE;
         end
         S_TRIM: begin
            ctrl_cmd.op = OP_TRIM;
            state_in    = S_RELEASE;
         end
         S_RELEASE: begin
            ctrl_cmd.op = OP_RELEASE;
            state_in    = S_FINISH;
         end
         S_FINISH: begin
            if (dp_stat.rsp_free) begin
               ctrl_cmd.op = OP_RESULT;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

[sv/ordered_list_engine.sv]
// Top level of the ordered list engine: ordered list of signed 32-bit values in linked slots.
// Depends on olist_pkg, olist_ctrl, olist_datapath (which holds the olist_ram stores).
//
//   channel  | ports                          | word
//   ---------+--------------------------------+------------------------------------------
//   request  | req_valid, req_ready, req_data | cmd, item_value
//   response | rsp_valid, rsp_ready, rsp_data | status, found, position, count, empty_res
//
// One command at a time. Empty/full cases and spare codes go straight from dispatch to the
// result; pushes take a fresh or freed slot and link it, pop front unlinks the head; find,
// remove and pop back walk the links one slot per cycle through the value and link stores.
// The engine returns to idle after each result before the next word is taken.
// Reset clears the pointers, count and allocator at once; no clearing pass is run.
// Stalls: the response register holds a finished word while the next request is taken;
// a command finishing while that word still waits holds until rsp_ready.
`timescale 1ns / 1ps

module ordered_list_engine #(
   parameter int DEPTH = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  olist_pkg::req_word_type req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output olist_pkg::rsp_word_type rsp_data
);

   import olist_pkg::*;

   // Command and status between controller and datapath
   ctrl_cmd_type ctrl_cmd;
   dp_stat_type  dp_stat;

   // Sequence each command: allocate, link, walk, unlink, release, then post the result
   olist_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .dp_stat   (dp_stat),
      .ctrl_cmd  (ctrl_cmd)
   );

   // Hold the list pointers and stores; freed slots chain through the link store,
   // and never-used slots come from a fill counter
   olist_datapath #(.DEPTH(DEPTH)) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .ctrl_cmd  (ctrl_cmd),
      .dp_stat   (dp_stat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
